[rtl/mips_subset_instruction_execute_defines.svh]
// Assertion macros shared by the MIPS subset execute block.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH

// Implication checked at every rising edge of clk outside reset.
`define MSIE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold at a rising edge of clk outside reset.
`define MSIE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/msie_pkg.sv]
// Shared constants, opcodes and types of the MIPS subset execute block.
package msie_pkg;

	localparam int DMEM_AW    = 10;
	localparam int DMEM_WORDS = 2 ** DMEM_AW;
	localparam int RF_AW      = 5;
	localparam int RF_DEPTH   = 2 ** RF_AW;
	localparam int CFG_AW     = 3;

	localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;

	typedef enum logic [0:0] {
		CFG_TEXT_START     = 1'b0,
		CFG_PROGRAM_LENGTH = 1'b1
	} cfg_reg_t;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2b;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	localparam logic [RF_AW-1:0] REG_ZERO = 5'd0;
	localparam logic [RF_AW-1:0] REG_RA   = 5'd31;

	typedef struct packed {
		logic [31:0]      npc;
		logic             wr;
		logic [RF_AW-1:0] widx;
		logic [31:0]      wval;
		logic             load;
		logic             mw;
		logic [31:0]      maddr;
		logic [31:0]      mval;
		logic             halted;
		logic             illegal;
	} exec_t;

	typedef struct packed {
		logic             we;
		logic [RF_AW-1:0] waddr;
		logic [31:0]      wdata;
	} rf_wr_t;

	typedef struct packed {
		logic               re;
		logic               we;
		logic [DMEM_AW-1:0] addr;
		logic [31:0]        wdata;
	} dmem_req_t;

endpackage

[rtl/msie_regfile.sv]
// Register file: two registered read ports, one write port, per-entry valid bits.
module msie_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      re,
	input  logic [msie_pkg::RF_AW-1:0] raddr_a,
	input  logic [msie_pkg::RF_AW-1:0] raddr_b,
	input  msie_pkg::rf_wr_t          wr,
	output logic [31:0]               rdata_a,
	output logic [31:0]               rdata_b
);
	import msie_pkg::*;

	logic [31:0]         mem [RF_DEPTH];
	logic [RF_DEPTH-1:0] vld_q;
	logic [31:0]         ra_q;
	logic [31:0]         rb_q;
	logic                va_q;
	logic                vb_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		if (re) begin
			ra_q <= mem[raddr_a];
			rb_q <= mem[raddr_b];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.waddr] <= 1'b1;
			end
			if (re) begin
				va_q <= vld_q[raddr_a];
				vb_q <= vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = va_q ? ra_q : 32'd0;
	assign rdata_b = vb_q ? rb_q : 32'd0;

endmodule

[rtl/msie_dmem.sv]
// Data memory with registered read and a clearing pass after reset.
module msie_dmem (
	input  logic                clk,
	input  logic                arst_n,
	input  msie_pkg::dmem_req_t req,
	output logic [31:0]         rdata,
	output logic                busy
);
	import msie_pkg::*;

	logic [31:0]        mem [DMEM_WORDS];
	logic [31:0]        rdata_q;
	logic [DMEM_AW-1:0] clr_idx_q;
	logic               clr_busy_q;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= 32'd0;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == DMEM_AW'(DMEM_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

[rtl/msie_exec.sv]
// Decode, ALU, branch and halt logic of the execute stage.
module msie_exec (
	input  logic [31:0]     instr,
	input  logic [31:0]     pc,
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	input  logic [32:0]     prog_end,
	output msie_pkg::exec_t ex
);
	import msie_pkg::*;

	logic [5:0]       op;
	logic [5:0]       fn;
	logic [RF_AW-1:0] rt;
	logic [RF_AW-1:0] rd;
	logic [4:0]       sh;
	logic [15:0]      imm;
	logic [31:0]      simm;
	logic [31:0]      zimm;
	logic [31:0]      pc4;
	logic [31:0]      sum_i;
	logic [31:0]      btarget;
	logic [31:0]      jtarget;
	logic             halt;

	assign op      = instr[31:26];
	assign rt      = instr[20:16];
	assign rd      = instr[15:11];
	assign sh      = instr[10:6];
	assign fn      = instr[5:0];
	assign imm     = instr[15:0];
	assign simm    = {{16{imm[15]}}, imm};
	assign zimm    = {16'd0, imm};
	assign pc4     = pc + 32'd4;
	assign sum_i   = a + simm;
	assign btarget = pc4 + {simm[29:0], 2'b00};
	assign jtarget = {pc4[31:28], instr[25:0], 2'b00};
	// The program end is formed one bit wider so that it cannot wrap.
	assign halt    = {1'b0, pc} >= prog_end;

	always_comb begin
		ex     = '0;
		ex.npc = pc4;
		case (op)
			OP_ADDIU: begin
				ex.wr = 1'b1; ex.widx = rt; ex.wval = sum_i;
			end
			OP_ANDI: begin
				ex.wr = 1'b1; ex.widx = rt; ex.wval = a & zimm;
			end
			OP_LUI: begin
				ex.wr = 1'b1; ex.widx = rt; ex.wval = {imm, 16'd0};
			end
			OP_ORI: begin
				ex.wr = 1'b1; ex.widx = rt; ex.wval = a | zimm;
			end
			OP_SLTIU: begin
				ex.wr = 1'b1; ex.widx = rt; ex.wval = {31'd0, a < simm};
			end
			OP_LW: begin
				ex.wr = 1'b1; ex.widx = rt; ex.load = 1'b1; ex.maddr = sum_i;
			end
			OP_SW: begin
				ex.mw = 1'b1; ex.maddr = sum_i; ex.mval = b;
			end
			OP_BEQ: begin
				if (a == b) ex.npc = btarget;
			end
			OP_BNE: begin
				if (a != b) ex.npc = btarget;
			end
			OP_J: begin
				ex.npc = jtarget;
			end
			OP_JAL: begin
				ex.wr = 1'b1; ex.widx = REG_RA; ex.wval = pc4; ex.npc = jtarget;
			end
			OP_SPECIAL: begin
				case (fn)
					FN_ADDU: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a + b; end
					FN_AND:  begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a & b; end
					FN_NOR:  begin ex.wr = 1'b1; ex.widx = rd; ex.wval = ~(a | b); end
					FN_OR:   begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a | b; end
					FN_SLTU: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = {31'd0, a < b}; end
					FN_SLL:  begin ex.wr = 1'b1; ex.widx = rd; ex.wval = b << sh; end
					FN_SRL:  begin ex.wr = 1'b1; ex.widx = rd; ex.wval = b >> sh; end
					FN_SUBU: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a - b; end
					FN_JR:   begin ex.npc = a; end
					default: begin ex.illegal = 1'b1; end
				endcase
			end
			default: begin
				ex.illegal = 1'b1;
			end
		endcase

		if (ex.illegal) begin
			ex         = '0;
			ex.illegal = 1'b1;
			ex.npc     = pc;
		end
		if (halt) begin
			ex        = '0;
			ex.halted = 1'b1;
			ex.npc    = pc;
		end
		// A write to register zero is dropped; a load still reports its address.
		if (ex.wr && ex.widx == REG_ZERO) begin
			ex.wr   = 1'b0;
			ex.wval = 32'd0;
			ex.load = 1'b0;
		end
	end

endmodule

[rtl/mips_subset_instruction_execute.sv]
// Executes one MIPS-32 subset instruction per beat against a register file and a
// data memory. An instruction beat is accepted into the execute stage, where operands
// come from the register file read ports or are forwarded from the write-back stage
// and the last write; the write-back stage then takes load data from the data memory
// and writes the register file, and the result beat is held in an output register.
// A result passes from the execute stage through the write-back stage to the output
// register, and one instruction is accepted every cycle while results are taken. After
// reset the data memory is cleared one word per cycle, so no instruction is accepted
// until all 1024 words are cleared; configuration writes are taken at any time.
`include "mips_subset_instruction_execute_defines.svh"

module mips_subset_instruction_execute (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msie_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        instr_valid,
	output logic                        instr_ready,
	input  logic [31:0]                 instruction_word,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [31:0]                 next_pc,
	output logic                        reg_written,
	output logic [msie_pkg::RF_AW-1:0]  reg_index,
	output logic [31:0]                 reg_value,
	output logic                        mem_written,
	output logic [31:0]                 mem_address,
	output logic [31:0]                 mem_value,
	output logic                        halted,
	output logic                        illegal
);
	import msie_pkg::*;

	logic [31:0]      text_start_q;
	logic [16:0]      prog_len_q;
	logic [32:0]      prog_end_q;
	logic             cfg_wr;
	logic [31:0]      pc_q;

	logic             advance;
	logic             accept;
	logic             dmem_busy;
	logic [31:0]      dmem_rdata;
	dmem_req_t        dmem_req;

	logic             valid_s1;
	logic [31:0]      instr_s1;
	logic [RF_AW-1:0] rs_s1;
	logic [RF_AW-1:0] rt_s1;
	logic [31:0]      rf_a;
	logic [31:0]      rf_b;
	logic [31:0]      op_a;
	logic [31:0]      op_b;
	exec_t            ex;

	logic             valid_s2;
	exec_t            ex_s2;
	logic [31:0]      wb_val_s2;
	logic             fwd_s2;
	rf_wr_t           rf_wr;

	logic             wb_vld_q;
	logic [RF_AW-1:0] wb_idx_q;
	logic [31:0]      wb_val_q;

	logic             res_valid_q;
	exec_t            res_d;
	exec_t            res_q;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_start_q <= TEXT_START_RST;
			prog_len_q   <= '0;
			prog_end_q   <= {1'b0, TEXT_START_RST};
		end else begin
			if (cfg_wr) begin
				case (cfg_reg_t'(paddr[2]))
					CFG_TEXT_START:     text_start_q <= pwdata;
					CFG_PROGRAM_LENGTH: prog_len_q   <= pwdata[16:0];
					default:            text_start_q <= text_start_q;
				endcase
			end
			prog_end_q <= {1'b0, text_start_q} + {14'd0, prog_len_q, 2'b00};
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[2]))
			CFG_TEXT_START:     prdata = text_start_q;
			CFG_PROGRAM_LENGTH: prdata = {15'd0, prog_len_q};
			default:            prdata = 32'd0;
		endcase
	end

	// The whole pipeline moves when the output register is free or being emptied.
	assign advance     = !res_valid_q || result_ready;
	assign instr_ready = advance && !dmem_busy;
	assign accept      = instr_valid && instr_ready;

	msie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.raddr_a (instruction_word[25:21]),
		.raddr_b (instruction_word[20:16]),
		.wr      (rf_wr),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// Execute stage.
	assign rs_s1     = instr_s1[25:21];
	assign rt_s1     = instr_s1[20:16];
	assign wb_val_s2 = ex_s2.load ? dmem_rdata : ex_s2.wval;
	assign fwd_s2    = valid_s2 && ex_s2.wr;

	// The write-back stage is newest; the last write covers a read that raced it.
	always_comb begin
		if (fwd_s2 && ex_s2.widx == rs_s1) begin
			op_a = wb_val_s2;
		end else if (wb_vld_q && wb_idx_q == rs_s1) begin
			op_a = wb_val_q;
		end else begin
			op_a = rf_a;
		end
		if (fwd_s2 && ex_s2.widx == rt_s1) begin
			op_b = wb_val_s2;
		end else if (wb_vld_q && wb_idx_q == rt_s1) begin
			op_b = wb_val_q;
		end else begin
			op_b = rf_b;
		end
	end

	msie_exec u_exec (
		.instr    (instr_s1),
		.pc       (pc_q),
		.a        (op_a),
		.b        (op_b),
		.prog_end (prog_end_q),
		.ex       (ex)
	);

	assign dmem_req.re    = valid_s1 && advance && ex.load;
	assign dmem_req.we    = valid_s1 && advance && ex.mw;
	assign dmem_req.addr  = ex.maddr[DMEM_AW+1:2];
	assign dmem_req.wdata = ex.mval;

	msie_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dmem_req),
		.rdata  (dmem_rdata),
		.busy   (dmem_busy)
	);

	assign rf_wr.we    = valid_s2 && advance && ex_s2.wr;
	assign rf_wr.waddr = ex_s2.widx;
	assign rf_wr.wdata = wb_val_s2;

	// The result beat carries the write-back value, which for a load is the memory data.
	always_comb begin
		res_d      = ex_s2;
		res_d.wval = wb_val_s2;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction_word;
		end
		if (advance) begin
			ex_s2 <= ex;
		end
		if (rf_wr.we) begin
			wb_idx_q <= rf_wr.waddr;
			wb_val_q <= rf_wr.wdata;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			wb_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			pc_q        <= TEXT_START_RST;
		end else begin
			if (advance) begin
				valid_s1    <= accept;
				valid_s2    <= valid_s1;
				res_valid_q <= valid_s2;
				if (valid_s1) begin
					pc_q <= ex.npc;
				end
			end
			if (rf_wr.we) begin
				wb_vld_q <= 1'b1;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign next_pc      = res_q.npc;
	assign reg_written  = res_q.wr;
	assign reg_index    = res_q.widx;
	assign reg_value    = res_q.wval;
	assign mem_written  = res_q.mw;
	assign mem_address  = res_q.maddr;
	assign mem_value    = res_q.mval;
	assign halted       = res_q.halted;
	assign illegal      = res_q.illegal;

	`MSIE_ASSERT_IMP(a_clear_blocks_input, dmem_busy, !instr_ready, "instruction taken during memory clear")
	`MSIE_ASSERT_NEVER(a_flags_exclusive, result_valid && halted && illegal, "halted and illegal together")
	`MSIE_ASSERT_IMP(a_no_zero_write, rf_wr.we, rf_wr.waddr != REG_ZERO, "write to register zero")
	`MSIE_ASSERT_NEVER(a_one_mem_access, dmem_req.re && dmem_req.we, "load and store in one cycle")
	`MSIE_ASSERT_IMP(a_stall_holds_pc, valid_s1 && !advance, pc_q == $past(pc_q) || $past(advance), "pc moved while stalled")

endmodule
